/* rtl/srq_pkg.sv */
// Shared types and constants of the shared receive queue free list.
`timescale 1ns / 1ps

package srq_pkg;

  localparam int unsigned MaxLogSlotsDef = 12;

  localparam int unsigned ModeW    = 2;
  localparam int unsigned SlotW    = 12;
  localparam int unsigned WorkIdW  = 64;
  localparam int unsigned CountW   = 32;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned LogW     = 4;

  localparam logic [LogW-1:0] MinLog   = LogW'(4);
  localparam logic [LogW-1:0] LogReset = LogW'(4);

  typedef enum logic [ModeW-1:0] {
    MODE_REBUILD = 2'd0,
    MODE_POST    = 2'd1,
    MODE_RETURN  = 2'd2,
    MODE_LOOKUP  = 2'd3
  } mode_e;

  typedef enum logic [StatusW-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_RANGE = 2'd2
  } status_e;

endpackage

/* rtl/srq_if.sv */
// Request and response channel interfaces of the shared receive queue free list.
`timescale 1ns / 1ps

interface srq_req_if;
  import srq_pkg::*;

  logic               valid;
  logic               ready;
  logic [ModeW-1:0]   mode;
  logic [SlotW-1:0]   slot_index;
  logic [WorkIdW-1:0] work_id;

  modport source (output valid, output mode, output slot_index, output work_id, input ready);
  modport sink   (input valid, input mode, input slot_index, input work_id, output ready);
endinterface

interface srq_rsp_if;
  import srq_pkg::*;

  logic               valid;
  logic               ready;
  logic [StatusW-1:0] status;
  logic [SlotW-1:0]   granted_slot;
  logic [WorkIdW-1:0] work_id_out;
  logic [SlotW-1:0]   free_slots;
  logic [CountW-1:0]  doorbell_count;

  modport source (output valid, output status, output granted_slot, output work_id_out,
                  output free_slots, output doorbell_count, input ready);
  modport sink   (input valid, input status, input granted_slot, input work_id_out,
                  input free_slots, input doorbell_count, output ready);
endinterface

/* rtl/srq_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps

module srq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

/* rtl/srq_ctrl.sv */
// Sequencer, pointer registers and the two slot memories of the free list.
`timescale 1ns / 1ps

module srq_ctrl #(
  parameter int unsigned MaxLogSlots = srq_pkg::MaxLogSlotsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [MaxLogSlots-1:0] size_mask_i,
  srq_req_if.sink                req_i,
  srq_rsp_if.source              rsp_o
);
  import srq_pkg::*;

  localparam int unsigned IdxW  = MaxLogSlots;
  localparam int unsigned Depth = 1 << IdxW;
  localparam int unsigned CmpW  = (IdxW > SlotW) ? IdxW : SlotW;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_REBUILD,
    ST_EXEC
  } state_e;

  state_e             state_q, state_d;
  logic [IdxW-1:0]    walk_q, walk_d;
  logic [IdxW-1:0]    head_q, head_d;
  logic [IdxW-1:0]    tail_q, tail_d;
  logic [IdxW-1:0]    free_q, free_d;
  logic [CountW-1:0]  posts_q, posts_d;
  mode_e              mode_q, mode_d;
  logic [SlotW-1:0]   idx_q, idx_d;
  logic [WorkIdW-1:0] wid_q, wid_d;
  logic               out_valid_q, out_valid_d;
  status_e            out_status_q, out_status_d;
  logic [SlotW-1:0]   out_granted_q, out_granted_d;
  logic [WorkIdW-1:0] out_wid_q, out_wid_d;
  logic [SlotW-1:0]   out_free_q, out_free_d;
  logic [CountW-1:0]  out_posts_q, out_posts_d;

  logic               accept;
  logic               exec_go;
  logic [CmpW-1:0]    idx_cmp, mask_cmp, req_idx_cmp, head_cmp, free_cmp;
  logic               idx_bad;
  logic [IdxW-1:0]    idx_slot;

  logic               link_we, wid_we;
  logic [IdxW-1:0]    link_waddr, link_wdata, link_rdata;
  logic [IdxW-1:0]    wid_waddr;
  logic [WorkIdW-1:0] wid_wdata, wid_rdata;

  assign req_i.ready = (state_q == ST_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign exec_go     = (state_q == ST_EXEC) && (!out_valid_q || rsp_o.ready);

  assign idx_cmp     = CmpW'(idx_q);
  assign mask_cmp    = CmpW'(size_mask_i);
  assign req_idx_cmp = CmpW'(req_i.slot_index);
  assign head_cmp    = CmpW'(head_q);
  assign idx_bad     = idx_cmp > mask_cmp;
  assign idx_slot    = idx_cmp[IdxW-1:0];

  srq_ram #(.Width(IdxW), .Depth(Depth)) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (link_waddr),
    .wdata_i (link_wdata),
    .re_i    (accept),
    .raddr_i (head_q),
    .rdata_o (link_rdata)
  );

  srq_ram #(.Width(WorkIdW), .Depth(Depth)) u_wid_ram (
    .clk_i   (clk_i),
    .we_i    (wid_we),
    .waddr_i (wid_waddr),
    .wdata_i (wid_wdata),
    .re_i    (accept),
    .raddr_i (req_idx_cmp[IdxW-1:0]),
    .rdata_o (wid_rdata)
  );

  always_comb begin
    state_d       = state_q;
    walk_d        = walk_q;
    head_d        = head_q;
    tail_d        = tail_q;
    free_d        = free_q;
    posts_d       = posts_q;
    mode_d        = mode_q;
    idx_d         = idx_q;
    wid_d         = wid_q;
    out_valid_d   = out_valid_q && !rsp_o.ready;
    out_status_d  = out_status_q;
    out_granted_d = out_granted_q;
    out_wid_d     = out_wid_q;
    out_free_d    = out_free_q;
    out_posts_d   = out_posts_q;
    link_we       = 1'b0;
    link_waddr    = walk_q;
    link_wdata    = '0;
    wid_we        = 1'b0;
    wid_waddr     = walk_q;
    wid_wdata     = '0;
    free_cmp      = '0;

    case (state_q)
      ST_CLEAR: begin
        wid_we = 1'b1;
        if (walk_q == {IdxW{1'b1}}) begin
          walk_d  = '0;
          state_d = ST_IDLE;
        end else begin
          walk_d = walk_q + 1'b1;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          mode_d  = mode_e'(req_i.mode);
          idx_d   = req_i.slot_index;
          wid_d   = req_i.work_id;
          walk_d  = '0;
          state_d = (mode_e'(req_i.mode) == MODE_REBUILD) ? ST_REBUILD : ST_EXEC;
        end
      end
      ST_REBUILD: begin
        link_we = 1'b1;
        wid_we  = 1'b1;
        if (walk_q == size_mask_i) begin
          link_wdata = '0;
          walk_d     = '0;
          state_d    = ST_EXEC;
        end else begin
          link_wdata = walk_q + 1'b1;
          walk_d     = walk_q + 1'b1;
        end
      end
      ST_EXEC: begin
        if (exec_go) begin
          state_d       = ST_IDLE;
          out_valid_d   = 1'b1;
          out_status_d  = STATUS_OK;
          out_granted_d = '0;
          out_wid_d     = '0;
          case (mode_q)
            MODE_REBUILD: begin
              head_d  = '0;
              tail_d  = size_mask_i;
              free_d  = size_mask_i;
              posts_d = '0;
            end
            MODE_POST: begin
              if (head_q == tail_q) begin
                out_status_d = STATUS_FULL;
              end else begin
                out_granted_d = head_cmp[SlotW-1:0];
                head_d        = link_rdata;
                if (free_q != '0) begin
                  free_d = free_q - 1'b1;
                end
                wid_we    = 1'b1;
                wid_waddr = head_q;
                wid_wdata = wid_q;
                posts_d   = posts_q + 1'b1;
              end
            end
            MODE_RETURN: begin
              if (idx_bad) begin
                out_status_d = STATUS_RANGE;
              end else begin
                link_we    = 1'b1;
                link_waddr = tail_q;
                link_wdata = idx_slot;
                tail_d     = idx_slot;
                free_d     = (free_q < size_mask_i) ? free_q + 1'b1 : size_mask_i;
              end
            end
            MODE_LOOKUP: begin
              if (idx_bad) begin
                out_status_d = STATUS_RANGE;
              end else begin
                out_wid_d = wid_rdata;
              end
            end
            default: begin
            end
          endcase
          free_cmp    = CmpW'(free_d);
          out_free_d  = free_cmp[SlotW-1:0];
          out_posts_d = posts_d;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_CLEAR;
      walk_q        <= '0;
      head_q        <= '0;
      tail_q        <= '0;
      free_q        <= '0;
      posts_q       <= '0;
      mode_q        <= MODE_REBUILD;
      idx_q         <= '0;
      wid_q         <= '0;
      out_valid_q   <= 1'b0;
      out_status_q  <= STATUS_OK;
      out_granted_q <= '0;
      out_wid_q     <= '0;
      out_free_q    <= '0;
      out_posts_q   <= '0;
    end else begin
      state_q       <= state_d;
      walk_q        <= walk_d;
      head_q        <= head_d;
      tail_q        <= tail_d;
      free_q        <= free_d;
      posts_q       <= posts_d;
      mode_q        <= mode_d;
      idx_q         <= idx_d;
      wid_q         <= wid_d;
      out_valid_q   <= out_valid_d;
      out_status_q  <= out_status_d;
      out_granted_q <= out_granted_d;
      out_wid_q     <= out_wid_d;
      out_free_q    <= out_free_d;
      out_posts_q   <= out_posts_d;
    end
  end

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.status         = out_status_q;
  assign rsp_o.granted_slot   = out_granted_q;
  assign rsp_o.work_id_out    = out_wid_q;
  assign rsp_o.free_slots     = out_free_q;
  assign rsp_o.doorbell_count = out_posts_q;

endmodule

/* rtl/srq_linked_free_list_top.sv */
// Top level of the shared receive queue free list: size register and sequencer.
`timescale 1ns / 1ps

// The block hands out and takes back the work-entry slots of one shared receive
// queue. The free slots form a chain in a link memory; a second memory keeps
// the work id stored with each posted slot.
// Requests arrive on req_i (mode, slot_index, work_id) and each one produces
// exactly one transaction on rsp_o (status, granted_slot, work_id_out,
// free_slots, doorbell_count). The queue size is set through cfg_we_i and
// cfg_wdata_i as log2 of the slot count, and must only be changed while the
// block is idle.
// For post, return and lookup the request is accepted, the memories are read
// on acceptance into their registered outputs, and the result is registered
// in the execute state once the output register is free.
// A rebuild walks the memories one slot a cycle. Only one request is in
// flight at a time.
// After reset the work id memory is cleared one entry a cycle, all
// 2^MaxLogSlots entries (4096 by default); no request is accepted meanwhile.
// If the receiver stalls, the result waits in the output register and the
// block still accepts the next request; it then holds that request until the
// output register is free.

module srq_linked_free_list_top #(
  parameter int unsigned MaxLogSlots = srq_pkg::MaxLogSlotsDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [srq_pkg::LogW-1:0]  cfg_wdata_i,
  srq_req_if.sink                   req_i,
  srq_rsp_if.source                 rsp_o
);
  import srq_pkg::*;

  localparam int unsigned EffW = LogW + 1;
  localparam logic [EffW-1:0] MaxLogExt = EffW'(MaxLogSlots);
  localparam logic [EffW-1:0] MinLogExt = EffW'(MinLog);

  logic [LogW-1:0]        cfg_q;
  logic [EffW-1:0]        cfg_ext;
  logic [EffW-1:0]        eff_log;
  logic [MaxLogSlots-1:0] size_mask;

  // The size register is written whenever the enable is high.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= LogReset;
    end else if (cfg_we_i) begin
      cfg_q <= cfg_wdata_i;
    end
  end

  // Values outside the supported range are clamped to the nearest limit.
  assign cfg_ext = {1'b0, cfg_q};
  always_comb begin
    if (cfg_ext < MinLogExt) begin
      eff_log = MinLogExt;
    end else if (cfg_ext > MaxLogExt) begin
      eff_log = MaxLogExt;
    end else begin
      eff_log = cfg_ext;
    end
  end

  // The mask equals the slot count minus one, the highest valid slot index.
  assign size_mask = ~({MaxLogSlots{1'b1}} << eff_log);

  srq_ctrl #(.MaxLogSlots(MaxLogSlots)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .size_mask_i (size_mask),
    .req_i       (req_i),
    .rsp_o       (rsp_o)
  );

endmodule

/* rtl/srq_checker.sv */
// Port-level assertions for the free list top level, with the bind that attaches them.
`timescale 1ns / 1ps

module srq_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          req_valid_i,
  input logic                          req_ready_i,
  input logic                          rsp_valid_i,
  input logic                          rsp_ready_i,
  input logic [srq_pkg::StatusW-1:0]   rsp_status_i,
  input logic [srq_pkg::SlotW-1:0]     rsp_granted_i,
  input logic [srq_pkg::WorkIdW-1:0]   rsp_work_id_i,
  input logic [srq_pkg::SlotW-1:0]     rsp_free_i,
  input logic [srq_pkg::CountW-1:0]    rsp_count_i
);
  import srq_pkg::*;

  // Only one request is in flight, so an accepted request closes the port.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request accepted while another was in flight");

  // A failed request grants nothing and returns no work id.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_status_i != STATUS_OK) |-> (rsp_granted_i == '0) &&
    (rsp_work_id_i == '0))
    else $error("failed request carries a slot or a work id");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("response withdrawn while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> $stable(rsp_status_i) && $stable(rsp_granted_i) &&
    $stable(rsp_work_id_i) && $stable(rsp_free_i) && $stable(rsp_count_i))
    else $error("response payload changed while stalled");

endmodule

bind srq_linked_free_list_top srq_checker u_srq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .req_valid_i   (req_i.valid),
  .req_ready_i   (req_i.ready),
  .rsp_valid_i   (rsp_o.valid),
  .rsp_ready_i   (rsp_o.ready),
  .rsp_status_i  (rsp_o.status),
  .rsp_granted_i (rsp_o.granted_slot),
  .rsp_work_id_i (rsp_o.work_id_out),
  .rsp_free_i    (rsp_o.free_slots),
  .rsp_count_i   (rsp_o.doorbell_count)
);

/* verif/srq_free_list_checker.sv */
// Scoreboard and free-list predictor of the shared receive queue testbench.
`timescale 1ns / 1ps

module srq_free_list_checker
  import srq_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [LogW-1:0]   cfg_wdata_i,
  srq_req_if                req_mon,
  srq_rsp_if                rsp_mon,
  output int unsigned       mismatch_count_o,
  output int unsigned       pending_o
);

  localparam int unsigned Depth      = 1 << MaxLogSlotsDef;
  localparam int unsigned MaxReports = 10;

  typedef struct packed {
    status_e            status;
    logic [SlotW-1:0]   granted_slot;
    logic [WorkIdW-1:0] work_id_out;
    logic [SlotW-1:0]   free_slots;
    logic [CountW-1:0]  doorbell_count;
  } slot_result_t;

  logic [SlotW-1:0]   link_mem    [Depth];
  logic [WorkIdW-1:0] work_id_mem [Depth];
  logic [SlotW-1:0]   head_q;
  logic [SlotW-1:0]   tail_q;
  logic [SlotW-1:0]   free_q;
  logic [CountW-1:0]  posts_q;
  logic [LogW-1:0]    log_q;
  slot_result_t       expected_results [$];
  int unsigned        mismatches;

  // Register values outside the supported range are clamped.
  function automatic int unsigned slots_in_use();
    int unsigned lg;
    lg = log_q;
    if (lg < MinLog) lg = MinLog;
    if (lg > MaxLogSlotsDef) lg = MaxLogSlotsDef;
    return 1 << lg;
  endfunction

  function automatic slot_result_t predict_result(mode_e mode, logic [SlotW-1:0] idx,
                                                  logic [WorkIdW-1:0] wid);
    int unsigned      sz;
    logic [SlotW-1:0] last;
    slot_result_t     r;
    sz   = slots_in_use();
    last = SlotW'(sz - 1);
    r    = '0;
    r.status = STATUS_OK;
    case (mode)
      MODE_REBUILD: begin
        for (int unsigned i = 0; i < sz; i++) begin
          link_mem[i]    = (i + 1 < sz) ? SlotW'(i + 1) : '0;
          work_id_mem[i] = '0;
        end
        head_q  = '0;
        tail_q  = last;
        free_q  = last;
        posts_q = '0;
      end
      MODE_POST: begin
        if (head_q == tail_q) begin
          r.status = STATUS_FULL;
        end else begin
          r.granted_slot      = head_q;
          work_id_mem[head_q] = wid;
          head_q              = link_mem[head_q];
          if (free_q != '0) free_q = free_q - 1'b1;
          posts_q = posts_q + 1'b1;
        end
      end
      MODE_RETURN: begin
        if (int'(idx) >= sz) begin
          r.status = STATUS_RANGE;
        end else begin
          link_mem[tail_q] = idx;
          tail_q           = idx;
          if (free_q < last) free_q = free_q + 1'b1;
          else free_q = last;
        end
      end
      default: begin
        if (int'(idx) >= sz) r.status = STATUS_RANGE;
        else r.work_id_out = work_id_mem[idx];
      end
    endcase
    r.free_slots     = free_q;
    r.doorbell_count = posts_q;
    return r;
  endfunction

  task automatic check_result(slot_result_t exp);
    logic bad;
    bad = 1'b0;
    if (rsp_mon.status !== exp.status) bad = 1'b1;
    if (rsp_mon.granted_slot !== exp.granted_slot) bad = 1'b1;
    if (rsp_mon.work_id_out !== exp.work_id_out) bad = 1'b1;
    if (rsp_mon.free_slots !== exp.free_slots) bad = 1'b1;
    if (rsp_mon.doorbell_count !== exp.doorbell_count) bad = 1'b1;
    if (bad) begin
      mismatches++;
      if (mismatches <= MaxReports) begin
        $display("%0t: response mismatch, expected status %0d slot %0d id %h free %0d db %0d",
                 $realtime, exp.status, exp.granted_slot, exp.work_id_out, exp.free_slots,
                 exp.doorbell_count);
        $display("%0t:                   actual   status %0d slot %0d id %h free %0d db %0d",
                 $realtime, rsp_mon.status, rsp_mon.granted_slot, rsp_mon.work_id_out,
                 rsp_mon.free_slots, rsp_mon.doorbell_count);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned i = 0; i < Depth; i++) begin
        link_mem[i]    = '0;
        work_id_mem[i] = '0;
      end
      head_q     = '0;
      tail_q     = '0;
      free_q     = '0;
      posts_q    = '0;
      log_q      = LogReset;
      mismatches = 0;
      expected_results.delete();
      mismatch_count_o <= 0;
      pending_o        <= 0;
    end else begin
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= MaxReports)
            $display("%0t: response transaction with no request outstanding", $realtime);
        end else begin
          check_result(expected_results.pop_front());
        end
      end
      if (req_mon.valid && req_mon.ready)
        expected_results.push_back(predict_result(mode_e'(req_mon.mode), req_mon.slot_index,
                                                  req_mon.work_id));
      if (cfg_we_i) log_q = cfg_wdata_i;
      mismatch_count_o <= mismatches;
      pending_o        <= expected_results.size();
    end
  end

endmodule

/* verif/tb_srq_linked_free_list_top.sv */
// Testbench top of the shared receive queue free list: stimulus, handshakes and verdict.
`timescale 1ns / 1ps

// The block is driven through its request channel with a short directed
// sequence and then with sixteen phases of random traffic, each with its own
// size register value. The checker beside the block predicts every response
// transaction and counts mismatches; this module only generates stimulus
// and reports the verdict.
module tb_srq_linked_free_list_top;
  import srq_pkg::*;

  localparam int unsigned NumPhases   = 16;
  localparam int unsigned PhaseItems  = 68;
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned DrainCycles = 10;
  // The run limit allows for the clearing pass after reset and the rebuilds
  // at the full size of 4096 slots.
  localparam longint unsigned RunLimitNs = 64'd5_000_000;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [LogW-1:0]   cfg_wdata_i;

  srq_req_if req_if ();
  srq_rsp_if rsp_if ();

  int unsigned       mismatch_count;
  int unsigned       pending_count;

  // Sizes for each phase, with the extremes and values outside the clamped
  // range. A clear flag means the size changes without a rebuild, so head
  // and tail keep their old values.
  int unsigned phase_log [NumPhases] = '{5, 0, 12, 3, 6, 13, 15, 7, 8, 9, 10, 11, 1, 2, 14, 4};
  bit          phase_rebuild [NumPhases] = '{1, 0, 1, 0, 1, 1, 0, 1, 1, 1, 1, 1, 0, 1, 1, 1};

  int unsigned       cur_log;
  bit                gaps_on;
  int unsigned       reqs_accepted;
  int unsigned       rsps_accepted;
  mode_e             modes_in_flight [$];
  logic [SlotW-1:0]  granted_pool [$];
  mode_e             done_mode;

  srq_linked_free_list_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_if),
    .rsp_o       (rsp_if)
  );

  srq_free_list_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .req_mon          (req_if),
    .rsp_mon          (rsp_if),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending_count)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Slot count for the current register value, clamped as the block does.
  function automatic int unsigned slot_count();
    int unsigned lg;
    lg = cur_log;
    if (lg < MinLog) lg = MinLog;
    if (lg > MaxLogSlotsDef) lg = MaxLogSlotsDef;
    return 1 << lg;
  endfunction

  // Track the transactions in flight. Slots granted by successful posts are
  // kept in a pool, so that most returns and lookups hit slots that are
  // really outstanding and the chain is exercised the way a driver uses it.
  always @(posedge clk_i) begin
    if (req_if.valid && req_if.ready) begin
      modes_in_flight.push_back(mode_e'(req_if.mode));
      reqs_accepted <= reqs_accepted + 1;
    end
    if (rsp_if.valid && rsp_if.ready) begin
      rsps_accepted <= rsps_accepted + 1;
      if (modes_in_flight.size() != 0) begin
        done_mode = modes_in_flight.pop_front();
        if (done_mode == MODE_POST && rsp_if.status == STATUS_OK)
          granted_pool.push_back(rsp_if.granted_slot);
      end
    end
  end

  // The receiver stalls in random bursts while gaps are enabled.
  initial begin
    int stall;
    stall = 0;
    rsp_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall > 0 && gaps_on) begin
        rsp_if.ready <= 1'b0;
        stall--;
      end else if (gaps_on && $urandom_range(0, 9) == 0) begin
        rsp_if.ready <= 1'b0;
        stall = $urandom_range(1, 16) - 1;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // Present one request and hold it until the block accepts it. The task
  // returns in the time step of the acceptance, so the next call either
  // drops valid for a gap or presents its fields in that same step.
  task automatic issue_request(input mode_e mode, input logic [SlotW-1:0] idx,
                               input logic [WorkIdW-1:0] wid);
    int gap;
    if (gaps_on && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 16);
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid      <= 1'b1;
    req_if.mode       <= mode;
    req_if.slot_index <= idx;
    req_if.work_id    <= wid;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  // Every request produces one response, so the block is idle once the two
  // counts agree. The counts are compared from the next edge on, when the
  // last acceptance has been counted.
  task automatic wait_for_quiet();
    @(posedge clk_i);
    wait (rsps_accepted == reqs_accepted);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_queue_size(input int unsigned lg);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= LogW'(lg);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cur_log      = lg;
  endtask

  function automatic logic [WorkIdW-1:0] random_work_id();
    return {$urandom, $urandom};
  endfunction

  // A returned slot: mostly one handed out earlier, sometimes any slot in
  // range (a duplicate return), sometimes one beyond the queue size.
  function automatic logic [SlotW-1:0] pick_return_slot(input int unsigned sz);
    int unsigned r;
    int unsigned k;
    logic [SlotW-1:0] s;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      s = (sz < 4096) ? SlotW'($urandom_range(sz, 4095)) : SlotW'($urandom_range(0, 4095));
    end else if (r < 18 || granted_pool.size() == 0) begin
      s = SlotW'($urandom_range(0, sz - 1));
    end else begin
      k = $urandom_range(0, granted_pool.size() - 1);
      s = granted_pool[k];
      granted_pool.delete(k);
    end
    return s;
  endfunction

  function automatic logic [SlotW-1:0] pick_lookup_slot(input int unsigned sz);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return SlotW'($urandom_range(0, 4095));
    if (r < 30 || granted_pool.size() == 0) return SlotW'($urandom_range(0, sz - 1));
    return granted_pool[$urandom_range(0, granted_pool.size() - 1)];
  endfunction

  // Random traffic in runs of one kind: long runs of posts fill the queue,
  // runs of returns refill it, lookups read back the stored work ids, and
  // an occasional rebuild starts the chain afresh.
  task automatic run_random_phase(input int unsigned n_items);
    int unsigned sent;
    int unsigned kind;
    int unsigned run;
    int unsigned sz;
    sent = 0;
    sz   = slot_count();
    while (sent < n_items) begin
      kind = $urandom_range(0, 99);
      if (kind < 3) begin
        issue_request(MODE_REBUILD, SlotW'($urandom), random_work_id());
        granted_pool.delete();
        sent++;
      end else if (kind < 40) begin
        run = $urandom_range(1, 20);
        repeat (run) issue_request(MODE_POST, SlotW'($urandom), random_work_id());
        sent += run;
      end else if (kind < 75) begin
        run = $urandom_range(1, 12);
        repeat (run) issue_request(MODE_RETURN, pick_return_slot(sz), random_work_id());
        sent += run;
      end else begin
        run = $urandom_range(1, 12);
        repeat (run) issue_request(MODE_LOOKUP, pick_lookup_slot(sz), random_work_id());
        sent += run;
      end
    end
  endtask

  initial begin
    #(RunLimitNs);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_wdata_i       = LogReset;
    req_if.valid      = 1'b0;
    req_if.mode       = MODE_REBUILD;
    req_if.slot_index = '0;
    req_if.work_id    = '0;
    reqs_accepted     = 0;
    rsps_accepted     = 0;
    cur_log           = LogReset;
    gaps_on           = 1'b1;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part at the reset size of 16 slots. Straight after reset head
    // and tail are both zero, so a post finds the queue full and the free
    // count starts at zero.
    issue_request(MODE_POST, '0, '1);
    issue_request(MODE_LOOKUP, '0, '0);
    issue_request(MODE_LOOKUP, '1, '0);
    issue_request(MODE_RETURN, '1, '0);
    issue_request(MODE_RETURN, SlotW'(5), '0);
    issue_request(MODE_POST, '0, '1);
    issue_request(MODE_POST, '0, '0);
    issue_request(MODE_LOOKUP, '0, '0);
    // After a rebuild the free count is already at its ceiling, so a return
    // saturates it.
    issue_request(MODE_REBUILD, '1, '1);
    issue_request(MODE_RETURN, SlotW'(3), '0);
    issue_request(MODE_POST, '1, '0);
    issue_request(MODE_POST, '0, '1);
    issue_request(MODE_POST, '0, 64'hA5A5_5A5A_0F0F_F0F0);
    issue_request(MODE_LOOKUP, SlotW'(0), '0);
    issue_request(MODE_LOOKUP, SlotW'(1), '0);
    issue_request(MODE_LOOKUP, SlotW'(2), '0);
    // A duplicate return relinks the chain exactly as it is told.
    issue_request(MODE_RETURN, SlotW'(0), '0);
    issue_request(MODE_RETURN, SlotW'(0), '0);
    issue_request(MODE_RETURN, SlotW'(15), '0);
    issue_request(MODE_RETURN, SlotW'(16), '0);
    issue_request(MODE_LOOKUP, SlotW'(15), '0);
    issue_request(MODE_LOOKUP, SlotW'(16), '0);
    issue_request(MODE_POST, '0, random_work_id());

    // Random phases. The size is only written while nothing is in flight.
    // Gaps are left out of some phases, and out of the last part entirely.
    for (int p = 0; p < NumPhases; p++) begin
      req_if.valid <= 1'b0;
      wait_for_quiet();
      gaps_on = (p < NumPhases - 2) && (p % 5 != 3);
      write_queue_size(phase_log[p]);
      if (phase_rebuild[p]) begin
        issue_request(MODE_REBUILD, SlotW'($urandom), random_work_id());
        granted_pool.delete();
      end
      run_random_phase(PhaseItems);
    end
    req_if.valid <= 1'b0;

    wait_for_quiet();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
